/* rtl/core/sbpd_pkg.sv */
// shared types and constants of the servo bus packet deframer
package sbpd_pkg;

  // status codes of a result
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_LONG = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_BAD_SUM  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT  = 3'd5;

  // input item kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // configuration register indexes
  localparam logic CFG_EXP_ID  = 1'b0;
  localparam logic CFG_EXP_CMD = 1'b1;

  // packet layout
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam int POS_ID  = 2;
  localparam int POS_LEN = 3;
  localparam int POS_CMD = 4;
  localparam int POS_PAR = 5;
  localparam logic [7:0] LEN_MIN = 8'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // input transaction this cycle
    logic advance;     // parameter result taken, step to the next
    logic show_param;  // output carries a parameter result
  } sbpd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic verdict;     // accepted item produces a single status result
    logic params;      // accepted item completes a good packet with parameters
    logic last_param;  // current parameter is the final one
  } sbpd_stat_t;

endpackage

/* rtl/core/sbpd_ram.sv */
// generic simple dual port ram with registered read
module sbpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sbpd_dp.sv */
// datapath: header hunt, packet fields, checksum, parameter store, result fields
module sbpd_dp
  import sbpd_pkg::*;
#(
  parameter int BUFFER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sbpd_cmd_t   cmd,
  output sbpd_stat_t  stat,
  input  logic        in_kind,
  input  logic [7:0]  in_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic [2:0]  res_status,
  output logic        res_param_valid,
  output logic [7:0]  res_param_byte,
  output logic [3:0]  res_param_index,
  output logic [3:0]  res_param_count,
  output logic        res_last
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);

  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    cmdb_r, cmdb_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]    exp_id_r, exp_cmd_r;
  logic          verdict, params, wr_en;
  logic [7:0]    rd_byte;
  logic [8:0]    pos9;

  assign pos9 = 9'(fill_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r  <= '0;
      exp_cmd_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXP_ID:  exp_id_r  <= cfg_data;
        CFG_EXP_CMD: exp_cmd_r <= cfg_data;
        default:     exp_id_r  <= exp_id_r;
      endcase
    end
  end

  // per-byte packet logic
  always_comb begin
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    cmdb_nxt   = cmdb_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    verdict    = 1'b0;
    params     = 1'b0;
    wr_en      = 1'b0;
    if (cmd.accept) begin
      if (in_kind == KIND_TIMEOUT) begin
        verdict    = 1'b1;
        status_nxt = ST_TIMEOUT;
      end else if (fill_r == '0) begin
        if (in_byte == HEADER_BYTE) begin
          fill_nxt = FW'(1);
        end
      end else if (fill_r == FW'(1)) begin
        fill_nxt = (in_byte == HEADER_BYTE) ? FW'(2) : '0;
      end else begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + FW'(1);
        if (fill_r == FW'(POS_ID)) begin
          id_nxt  = in_byte;
          sum_nxt = sum_r + in_byte;
        end else if (fill_r == FW'(POS_LEN)) begin
          len_nxt = in_byte;
          if ({1'b0, in_byte} + 9'd3 > 9'(BUFFER_BYTES)) begin
            verdict    = 1'b1;
            status_nxt = ST_TOO_LONG;
          end else if (in_byte < LEN_MIN) begin
            verdict    = 1'b1;
            status_nxt = ST_TOO_SHORT;
          end else begin
            sum_nxt = sum_r + in_byte;
          end
        end else if (pos9 != {1'b0, len_r} + 9'd2) begin
          // command or parameter byte
          if (fill_r == FW'(POS_CMD)) begin
            cmdb_nxt = in_byte;
          end
          sum_nxt = sum_r + in_byte;
        end else begin
          // checksum byte closes the packet
          if (id_r != exp_id_r || cmdb_r != exp_cmd_r) begin
            verdict    = 1'b1;
            status_nxt = ST_MISMATCH;
          end else if (~sum_r != in_byte) begin
            verdict    = 1'b1;
            status_nxt = ST_BAD_SUM;
          end else if (len_r == LEN_MIN) begin
            verdict    = 1'b1;
            status_nxt = ST_OK;
          end else begin
            params  = 1'b1;
            cnt_nxt = AW'(len_r - LEN_MIN);
            idx_nxt = '0;
          end
        end
      end
      if (verdict || params) begin
        fill_nxt = '0;
        sum_nxt  = '0;
      end
    end
    if (cmd.advance) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    len_r    <= len_nxt;
    cmdb_r   <= cmdb_nxt;
    status_r <= status_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
  end

  // parameter byte store
  sbpd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(fill_r[AW-1:0]),
    .wdata(in_byte),
    .raddr(AW'(POS_PAR) + idx_r),
    .rdata(rd_byte)
  );

  // status back to the controller
  assign stat.verdict    = verdict;
  assign stat.params     = params;
  assign stat.last_param = (idx_r + AW'(1) == cnt_r);

  // result fields
  assign res_status      = cmd.show_param ? ST_OK : status_r;
  assign res_param_valid = cmd.show_param;
  assign res_param_byte  = cmd.show_param ? rd_byte : 8'd0;
  assign res_param_index = cmd.show_param ? 4'(idx_r) : 4'd0;
  assign res_param_count = cmd.show_param ? 4'(cnt_r) : 4'd0;
  assign res_last        = cmd.show_param ? stat.last_param : 1'b1;

endmodule

/* rtl/core/sbpd_ctrl.sv */
// controller: input acceptance and result sequencing
module sbpd_ctrl
  import sbpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output sbpd_cmd_t  cmd,
  input  sbpd_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STAT = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_PAR  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // handshakes and commands
  assign in_tready      = (state_r == S_IDLE);
  assign out_tvalid     = (state_r == S_STAT) || (state_r == S_PAR);
  assign cmd.accept     = in_tvalid && (state_r == S_IDLE);
  assign cmd.advance    = (state_r == S_PAR) && out_tready && !stat.last_param;
  assign cmd.show_param = (state_r == S_PAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.verdict) begin
          state_nxt = S_STAT;
        end else if (cmd.accept && stat.params) begin
          state_nxt = S_RD;
        end
      end
      S_STAT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      S_RD: begin
        state_nxt = S_PAR;
      end
      S_PAR: begin
        if (out_tready) state_nxt = stat.last_param ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an item that ends in a status result (failing, timed out or a good packet without parameters) shows it next
  a_verdict_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.verdict |=> state_r == S_STAT)
    else $error("status result not raised after verdict");

  // a good packet with parameters starts with a store read
  a_params_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.params |=> state_r == S_RD)
    else $error("parameter read not started");

  // taking the final parameter frees the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAR && out_tready && stat.last_param |=> in_tready)
    else $error("input not ready after final parameter");

endmodule

/* rtl/core/servo_bus_packet_deframer_unit.sv */
// top level of the servo bus packet deframer
//
//  channel  direction  transaction fields
//  in_      slave      tuser: kind; tdata: rx_byte
//  out_     master     tuser: param_valid; tlast: last;
//                      tdata: status, param_byte, param_index, param_count
//  cfg_     slave      cfg_index: register index; cfg_data: value
//
// a byte that gives no result leaves in_tready high
// an item that ends in a status result holds the input until that result is taken
// a good packet with parameters emits them one at a time; the store's
// registered read precedes every parameter result
// synchronous active low reset clears the header hunt, checksum, controller state and configuration registers;
// the parameter store is not cleared
// configuration writes are always taken (cfg_ready is tied high)
module servo_bus_packet_deframer_unit
  import sbpd_pkg::*;
#(
  parameter int BUFFER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [10:3] param_byte,
                                  // [14:11] param_index, [18:15] param_count,
                                  // [23:19] zero
  output logic        out_tuser,  // [0] param_valid
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  sbpd_cmd_t  cmd;
  sbpd_stat_t stat;
  logic [2:0] res_status;
  logic [7:0] res_param_byte;
  logic [3:0] res_param_index;
  logic [3:0] res_param_count;

  assign cfg_ready = 1'b1;

  // controller
  sbpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath
  sbpd_dp #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_tuser),
    .in_byte        (in_tdata),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .res_status     (res_status),
    .res_param_valid(out_tuser),
    .res_param_byte (res_param_byte),
    .res_param_index(res_param_index),
    .res_param_count(res_param_count),
    .res_last       (out_tlast)
  );

  // result packing
  assign out_tdata = {5'd0, res_param_count, res_param_index, res_param_byte, res_status};

endmodule
